// File: hdl/krf_pkg.sv
// ----------------------------------------------------------------------------
// Khazad round function package
// Shared constants, the S-box table, the theta matrix and GF(2^8) helpers
// used by the round function unit and its theta layer.
// ----------------------------------------------------------------------------
package krf_pkg;

   // Widths of the payload and the register port
   localparam int KRF_BLOCK_W = 64;
   localparam int KRF_BYTES   = KRF_BLOCK_W / 8;
   localparam int KRF_IDX_W   = 8;
   localparam int KRF_EN_W    = 3;

   // Register indexes on the csr port
   typedef enum logic [KRF_IDX_W-1:0] {
      KRF_REG_ROUND_KEY    = 8'd0,
      KRF_REG_STAGE_ENABLE = 8'd1
   } krf_reg_type;

   // Stage enable bit positions
   localparam int KRF_EN_KEY   = 0;
   localparam int KRF_EN_SBOX  = 1;
   localparam int KRF_EN_THETA = 2;

   localparam logic [KRF_EN_W-1:0] KRF_EN_RESET = 3'h7;

   // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
   localparam logic [7:0] KRF_POLY_LO = 8'h1d;

   // Khazad S-box
   localparam logic [7:0] KRF_SBOX [0:255] = '{
      8'hBA,8'h54,8'h2F,8'h74,8'h53,8'hD3,8'hD2,8'h4D,
      8'h50,8'hAC,8'h8D,8'hBF,8'h70,8'h52,8'h9A,8'h4C,
      8'hEA,8'hD5,8'h97,8'hD1,8'h33,8'h51,8'h5B,8'hA6,
      8'hDE,8'h48,8'hA8,8'h99,8'hDB,8'h32,8'hB7,8'hFC,
      8'hE3,8'h9E,8'h91,8'h9B,8'hE2,8'hBB,8'h41,8'h6E,
      8'hA5,8'hCB,8'h6B,8'h95,8'hA1,8'hF3,8'hB1,8'h02,
      8'hCC,8'hC4,8'h1D,8'h14,8'hC3,8'h63,8'hDA,8'h5D,
      8'h5F,8'hDC,8'h7D,8'hCD,8'h7F,8'h5A,8'h6C,8'h5C,
      8'hF7,8'h26,8'hFF,8'hED,8'hE8,8'h9D,8'h6F,8'h8E,
      8'h19,8'hA0,8'hF0,8'h89,8'h0F,8'h07,8'hAF,8'hFB,
      8'h08,8'h15,8'h0D,8'h04,8'h01,8'h64,8'hDF,8'h76,
      8'h79,8'hDD,8'h3D,8'h16,8'h3F,8'h37,8'h6D,8'h38,
      8'hB9,8'h73,8'hE9,8'h35,8'h55,8'h71,8'h7B,8'h8C,
      8'h72,8'h88,8'hF6,8'h2A,8'h3E,8'h5E,8'h27,8'h46,
      8'h0C,8'h65,8'h68,8'h61,8'h03,8'hC1,8'h57,8'hD6,
      8'hD9,8'h58,8'hD8,8'h66,8'hD7,8'h3A,8'hC8,8'h3C,
      8'hFA,8'h96,8'hA7,8'h98,8'hEC,8'hB8,8'hC7,8'hAE,
      8'h69,8'h4B,8'hAB,8'hA9,8'h67,8'h0A,8'h47,8'hF2,
      8'hB5,8'h22,8'hE5,8'hEE,8'hBE,8'h2B,8'h81,8'h12,
      8'h83,8'h1B,8'h0E,8'h23,8'hF5,8'h45,8'h21,8'hCE,
      8'h49,8'h2C,8'hF9,8'hE6,8'hB6,8'h28,8'h17,8'h82,
      8'h1A,8'h8B,8'hFE,8'h8A,8'h09,8'hC9,8'h87,8'h4E,
      8'hE1,8'h2E,8'hE4,8'hE0,8'hEB,8'h90,8'hA4,8'h1E,
      8'h85,8'h60,8'h00,8'h25,8'hF4,8'hF1,8'h94,8'h0B,
      8'hE7,8'h75,8'hEF,8'h34,8'h31,8'hD4,8'hD0,8'h86,
      8'h7E,8'hAD,8'hFD,8'h29,8'h30,8'h3B,8'h9F,8'hF8,
      8'hC6,8'h13,8'h06,8'h05,8'hC5,8'h11,8'h77,8'h7C,
      8'h7A,8'h78,8'h36,8'h1C,8'h39,8'h59,8'h18,8'h56,
      8'hB3,8'hB0,8'h24,8'h20,8'hB2,8'h92,8'hA3,8'hC0,
      8'h44,8'h62,8'h10,8'hB4,8'h84,8'h43,8'h93,8'hC2,
      8'h4A,8'hBD,8'h8F,8'h2D,8'hBC,8'h9C,8'h6A,8'h40,
      8'hCF,8'hA2,8'h80,8'h4F,8'h1F,8'hCA,8'hAA,8'h42
   };

   // Theta matrix, indexed [j][i]; all entries fit in 4 bits
   localparam logic [3:0] KRF_THETA_M [0:7][0:7] = '{
      '{4'h1,4'h3,4'h4,4'h5,4'h6,4'h8,4'hB,4'h7},
      '{4'h3,4'h1,4'h5,4'h4,4'h8,4'h6,4'h7,4'hB},
      '{4'h4,4'h5,4'h1,4'h3,4'hB,4'h7,4'h6,4'h8},
      '{4'h5,4'h4,4'h3,4'h1,4'h7,4'hB,4'h8,4'h6},
      '{4'h6,4'h8,4'hB,4'h7,4'h1,4'h3,4'h4,4'h5},
      '{4'h8,4'h6,4'h7,4'hB,4'h3,4'h1,4'h5,4'h4},
      '{4'hB,4'h7,4'h6,4'h8,4'h4,4'h5,4'h1,4'h3},
      '{4'h7,4'hB,4'h8,4'h6,4'h5,4'h4,4'h3,4'h1}
   };

   // Multiply by x modulo the field polynomial
   function automatic logic [7:0] krf_xtime(input logic [7:0] a);
      krf_xtime = {a[6:0], 1'b0} ^ (a[7] ? KRF_POLY_LO : 8'h00);
   endfunction

   // Multiply by a 4-bit constant: a few shifted copies XORed together
   function automatic logic [7:0] krf_gmul(input logic [3:0] c, input logic [7:0] a);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = 8'h00;
      sh  = a;
      for (int n = 0; n < 4; n++) begin
         if (c[n]) acc = acc ^ sh;
         sh = krf_xtime(sh);
      end
      krf_gmul = acc;
   endfunction

endpackage

// File: hdl/khazad_round_function_unit.sv
// ----------------------------------------------------------------------------
// Khazad round function unit
// Applies key XOR, S-box layer and theta layer to a 64-bit block, each stage
// gated by a bit of stage_enable. Register port sets round_key and the mask.
// ----------------------------------------------------------------------------
// Path: a request taken into the input register moves to the response register once that is free.
// Throughput: one request per cycle while no stalled response holds off the input; the input
//   register feeds the round logic, which drives the response register directly.
// Stall: a stalled response only holds off the input while the input
//   register is also full.
// Reset (synchronous): pipeline emptied, round_key = 0, stage_enable = 7.
module khazad_round_function_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [krf_pkg::KRF_BLOCK_W-1:0]     req_block_in,
   input  logic                                req_last_in_set,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [krf_pkg::KRF_BLOCK_W-1:0]     rsp_block_out,
   output logic                                rsp_last_out,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [krf_pkg::KRF_IDX_W-1:0]       csr_index,
   input  logic [krf_pkg::KRF_BLOCK_W-1:0]     csr_wdata
);
   import krf_pkg::*;

   logic [KRF_BLOCK_W-1:0] round_key_ff, round_key_in;
   logic [KRF_EN_W-1:0]    stage_en_ff, stage_en_in;

   logic                   in_valid_ff, in_valid_in;
   logic [KRF_BLOCK_W-1:0] in_block_ff;
   logic                   in_last_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [KRF_BLOCK_W-1:0] out_block_ff;
   logic                   out_last_ff;

   logic                   out_free;
   logic                   in_adv;
   logic                   req_take;

   logic [KRF_BLOCK_W-1:0] key_x;
   logic [KRF_BLOCK_W-1:0] sbox_x;
   logic [KRF_BLOCK_W-1:0] sub_x;
   logic [KRF_BLOCK_W-1:0] theta_x;
   logic [KRF_BLOCK_W-1:0] round_x;

   // Register port: always ready, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_comb begin
      round_key_in = round_key_ff;
      stage_en_in  = stage_en_ff;
      if (csr_valid) begin
         unique case (csr_index)
            KRF_REG_ROUND_KEY:    round_key_in = csr_wdata;
            KRF_REG_STAGE_ENABLE: stage_en_in  = csr_wdata[KRF_EN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_key_ff <= '0;
         stage_en_ff  <= KRF_EN_RESET;
      end else begin
         round_key_ff <= round_key_in;
         stage_en_ff  <= stage_en_in;
      end
   end

   // Flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_adv    = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_adv || (out_valid_ff && !out_free);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_block_ff <= req_block_in;
         in_last_ff  <= req_last_in_set;
      end
   end

   // Key XOR stage
   assign key_x = stage_en_ff[KRF_EN_KEY] ? (in_block_ff ^ round_key_ff) : in_block_ff;

   // S-box layer, one table lookup per byte
   always_comb begin
      for (int k = 0; k < KRF_BYTES; k++) begin
         sbox_x[8*k +: 8] = KRF_SBOX[key_x[8*k +: 8]];
      end
   end

   assign sub_x = stage_en_ff[KRF_EN_SBOX] ? sbox_x : key_x;

   // Theta layer
   krf_theta u_theta (
      .data_in  (sub_x),
      .data_out (theta_x)
   );

   assign round_x = stage_en_ff[KRF_EN_THETA] ? theta_x : sub_x;

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         out_block_ff <= round_x;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_block_ff;
   assign rsp_last_out  = out_last_ff;

   // Checks
   a_adv_fills_out: assert property (@(posedge clock) disable iff (reset)
      in_adv |=> out_valid_ff)
      else $error("response register not loaded after advance");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (in_adv && (stage_en_ff == '0)) |=> (out_block_ff == $past(in_block_ff)))
      else $error("block changed with all stages disabled");

   a_last_copy: assert property (@(posedge clock) disable iff (reset)
      in_adv |=> (out_last_ff == $past(in_last_ff)))
      else $error("last flag not carried with its block");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_adv) |=> in_valid_ff)
      else $error("held request lost from input register");

endmodule

// File: hdl/krf_theta.sv
// ----------------------------------------------------------------------------
// Khazad theta layer
// Byte-wise linear diffusion: out byte i is the XOR over j of M[j][i] times
// in byte 7-j in GF(2^8). Purely combinational, constant multipliers only.
// ----------------------------------------------------------------------------
module krf_theta (
   input  logic [krf_pkg::KRF_BLOCK_W-1:0] data_in,
   output logic [krf_pkg::KRF_BLOCK_W-1:0] data_out
);
   import krf_pkg::*;

   // One output byte per lane, eight constant products each
   always_comb begin
      logic [7:0] acc;
      data_out = '0;
      for (int i = 0; i < KRF_BYTES; i++) begin
         acc = 8'h00;
         for (int j = 0; j < KRF_BYTES; j++) begin
            acc = acc ^ krf_gmul(KRF_THETA_M[j][i], data_in[8*(KRF_BYTES-1-j) +: 8]);
         end
         data_out[8*i +: 8] = acc;
      end
   end

endmodule

// File: test/tb_khazad_round_function_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Khazad round function unit testbench
// Sends 64-bit blocks through the unit under several stage masks and round
// keys. Sender gaps and response stalls vary by phase. Every response is
// checked against a typed-in result or a behavioral model of the key, S-box and theta stages.
// ----------------------------------------------------------------------------
module tb_khazad_round_function_unit;
   import krf_pkg::*;

   localparam int          HALF_PERIOD        = 6;
   localparam int          QUIET_LIMIT        = 5000;
   localparam int          SETTLE_CYCLES      = 4;
   localparam int          SEGMENTS           = 9;
   localparam int          BLOCKS_PER_SEGMENT = 50;
   localparam logic [7:0]  FIELD_POLY_LOW     = 8'h1d;
   localparam logic [63:0] ALL_ONES           = 64'hFFFF_FFFF_FFFF_FFFF;

   // Indexes with no register behind them
   localparam logic [KRF_IDX_W-1:0] REG_INDEX_UNUSED = KRF_IDX_W'(KRF_REG_STAGE_ENABLE + 1);
   localparam logic [KRF_IDX_W-1:0] REG_INDEX_TOP    = '1;

   // Khazad S-box
   localparam logic [7:0] SUBST [0:255] = '{
      8'hBA,8'h54,8'h2F,8'h74,8'h53,8'hD3,8'hD2,8'h4D,
      8'h50,8'hAC,8'h8D,8'hBF,8'h70,8'h52,8'h9A,8'h4C,
      8'hEA,8'hD5,8'h97,8'hD1,8'h33,8'h51,8'h5B,8'hA6,
      8'hDE,8'h48,8'hA8,8'h99,8'hDB,8'h32,8'hB7,8'hFC,
      8'hE3,8'h9E,8'h91,8'h9B,8'hE2,8'hBB,8'h41,8'h6E,
      8'hA5,8'hCB,8'h6B,8'h95,8'hA1,8'hF3,8'hB1,8'h02,
      8'hCC,8'hC4,8'h1D,8'h14,8'hC3,8'h63,8'hDA,8'h5D,
      8'h5F,8'hDC,8'h7D,8'hCD,8'h7F,8'h5A,8'h6C,8'h5C,
      8'hF7,8'h26,8'hFF,8'hED,8'hE8,8'h9D,8'h6F,8'h8E,
      8'h19,8'hA0,8'hF0,8'h89,8'h0F,8'h07,8'hAF,8'hFB,
      8'h08,8'h15,8'h0D,8'h04,8'h01,8'h64,8'hDF,8'h76,
      8'h79,8'hDD,8'h3D,8'h16,8'h3F,8'h37,8'h6D,8'h38,
      8'hB9,8'h73,8'hE9,8'h35,8'h55,8'h71,8'h7B,8'h8C,
      8'h72,8'h88,8'hF6,8'h2A,8'h3E,8'h5E,8'h27,8'h46,
      8'h0C,8'h65,8'h68,8'h61,8'h03,8'hC1,8'h57,8'hD6,
      8'hD9,8'h58,8'hD8,8'h66,8'hD7,8'h3A,8'hC8,8'h3C,
      8'hFA,8'h96,8'hA7,8'h98,8'hEC,8'hB8,8'hC7,8'hAE,
      8'h69,8'h4B,8'hAB,8'hA9,8'h67,8'h0A,8'h47,8'hF2,
      8'hB5,8'h22,8'hE5,8'hEE,8'hBE,8'h2B,8'h81,8'h12,
      8'h83,8'h1B,8'h0E,8'h23,8'hF5,8'h45,8'h21,8'hCE,
      8'h49,8'h2C,8'hF9,8'hE6,8'hB6,8'h28,8'h17,8'h82,
      8'h1A,8'h8B,8'hFE,8'h8A,8'h09,8'hC9,8'h87,8'h4E,
      8'hE1,8'h2E,8'hE4,8'hE0,8'hEB,8'h90,8'hA4,8'h1E,
      8'h85,8'h60,8'h00,8'h25,8'hF4,8'hF1,8'h94,8'h0B,
      8'hE7,8'h75,8'hEF,8'h34,8'h31,8'hD4,8'hD0,8'h86,
      8'h7E,8'hAD,8'hFD,8'h29,8'h30,8'h3B,8'h9F,8'hF8,
      8'hC6,8'h13,8'h06,8'h05,8'hC5,8'h11,8'h77,8'h7C,
      8'h7A,8'h78,8'h36,8'h1C,8'h39,8'h59,8'h18,8'h56,
      8'hB3,8'hB0,8'h24,8'h20,8'hB2,8'h92,8'hA3,8'hC0,
      8'h44,8'h62,8'h10,8'hB4,8'h84,8'h43,8'h93,8'hC2,
      8'h4A,8'hBD,8'h8F,8'h2D,8'hBC,8'h9C,8'h6A,8'h40,
      8'hCF,8'hA2,8'h80,8'h4F,8'h1F,8'hCA,8'hAA,8'h42
   };

   // Theta coefficients, [j][i]
   localparam logic [7:0] MIX [0:7][0:7] = '{
      '{8'h1,8'h3,8'h4,8'h5,8'h6,8'h8,8'hB,8'h7},
      '{8'h3,8'h1,8'h5,8'h4,8'h8,8'h6,8'h7,8'hB},
      '{8'h4,8'h5,8'h1,8'h3,8'hB,8'h7,8'h6,8'h8},
      '{8'h5,8'h4,8'h3,8'h1,8'h7,8'hB,8'h8,8'h6},
      '{8'h6,8'h8,8'hB,8'h7,8'h1,8'h3,8'h4,8'h5},
      '{8'h8,8'h6,8'h7,8'hB,8'h3,8'h1,8'h5,8'h4},
      '{8'hB,8'h7,8'h6,8'h8,8'h4,8'h5,8'h1,8'h3},
      '{8'h7,8'hB,8'h8,8'h6,8'h5,8'h4,8'h3,8'h1}
   };

   typedef struct packed {
      logic [KRF_BLOCK_W-1:0] block;
      logic                   last;
   } round_result_type;

   // Directed request: register setting, block, and a typed-in result where known
   typedef struct packed {
      logic [KRF_EN_W-1:0]    enable;
      logic [KRF_BLOCK_W-1:0] key;
      logic [KRF_BLOCK_W-1:0] block;
      logic                   last;
      logic                   known;
      logic [KRF_BLOCK_W-1:0] result;
   } directed_row_type;

   directed_row_type directed_rows [0:21] = '{
      // reset setting: all stages, zero key
      '{3'b111, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
      '{3'b111, 64'h0, ALL_ONES, 1'b1, 1'b0, 64'h0},
      '{3'b111, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0},
      // all stages off: block passes through
      '{3'b000, 64'h0, 64'h0, 1'b0, 1'b1, 64'h0},
      '{3'b000, 64'h0, ALL_ONES, 1'b1, 1'b1, ALL_ONES},
      '{3'b000, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 64'h0123_4567_89AB_CDEF},
      // key stage only
      '{3'b001, ALL_ONES, 64'h0, 1'b1, 1'b1, ALL_ONES},
      '{3'b001, ALL_ONES, ALL_ONES, 1'b0, 1'b1, 64'h0},
      '{3'b001, 64'h0F0F_0F0F_0F0F_0F0F, 64'h00FF_00FF_00FF_00FF, 1'b1, 1'b1,
        64'h0FF0_0FF0_0FF0_0FF0},
      // S-box only, byte order checked by an ascending block
      '{3'b010, ALL_ONES, 64'h0, 1'b0, 1'b1, 64'hBABA_BABA_BABA_BABA},
      '{3'b010, ALL_ONES, ALL_ONES, 1'b1, 1'b1, 64'h4242_4242_4242_4242},
      '{3'b010, ALL_ONES, 64'h0706_0504_0302_0100, 1'b0, 1'b1, 64'h4DD2_D353_742F_54BA},
      // theta only: single-byte inputs pick out one matrix row
      '{3'b100, ALL_ONES, 64'h0, 1'b1, 1'b1, 64'h0},
      '{3'b100, ALL_ONES, 64'h0000_0000_0000_0001, 1'b0, 1'b1, 64'h0103_0405_0608_0B07},
      '{3'b100, ALL_ONES, 64'h0100_0000_0000_0000, 1'b1, 1'b1, 64'h070B_0806_0504_0301},
      '{3'b100, ALL_ONES, ALL_ONES, 1'b0, 1'b0, 64'h0},
      '{3'b100, ALL_ONES, 64'h8000_0000_0000_0080, 1'b1, 1'b0, 64'h0},
      // mixed masks
      '{3'b011, ALL_ONES, ALL_ONES, 1'b0, 1'b1, 64'hBABA_BABA_BABA_BABA},
      '{3'b101, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 64'h0},
      '{3'b110, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, 1'b0, 64'h0},
      '{3'b111, 64'h0, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
      '{3'b111, ALL_ONES, 64'h0, 1'b1, 1'b0, 64'h0}
   };

   // Random phases: stage mask per segment
   localparam logic [KRF_EN_W-1:0] SEGMENT_MASKS [0:SEGMENTS-1] = '{
      3'b111, 3'b111, 3'b011, 3'b101, 3'b110, 3'b001, 3'b010, 3'b100, 3'b000
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [KRF_BLOCK_W-1:0] req_block_in;
   logic                   req_last_in_set;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KRF_BLOCK_W-1:0] rsp_block_out;
   logic                   rsp_last_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [KRF_IDX_W-1:0]   csr_index;
   logic [KRF_BLOCK_W-1:0] csr_wdata;

   // Typed-in result travelling with the current request
   logic                   req_known;
   logic [KRF_BLOCK_W-1:0] req_golden;

   // Register copies kept by the testbench
   logic [KRF_BLOCK_W-1:0] model_key;
   logic [KRF_EN_W-1:0]    model_enable;

   round_result_type expected_rounds[$];
   int               mismatch_count;
   int               quiet_cycles;
   int               sender_idle_pct;
   int               receiver_stall_pct;

   khazad_round_function_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_in    (req_block_in),
      .req_last_in_set (req_last_in_set),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_block_out   (rsp_block_out),
      .rsp_last_out    (rsp_last_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // GF(2^8) product modulo x^8+x^4+x^3+x^2+1
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = 8'h00;
      sh  = a;
      for (int n = 0; n < 8; n++) begin
         if (b[n]) acc = acc ^ sh;
         sh = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_POLY_LOW : 8'h00);
      end
      return acc;
   endfunction

   // Expected response for one block under the current register copies
   function automatic round_result_type khazad_round(input logic [KRF_BLOCK_W-1:0] blk,
                                                     input logic lst);
      logic [KRF_BLOCK_W-1:0] x;
      logic [KRF_BLOCK_W-1:0] mixed;
      logic [7:0]             acc;
      round_result_type       res;
      x = blk;
      if (model_enable[KRF_EN_KEY]) x = x ^ model_key;
      if (model_enable[KRF_EN_SBOX]) begin
         for (int k = 0; k < KRF_BYTES; k++) x[8*k +: 8] = SUBST[x[8*k +: 8]];
      end
      if (model_enable[KRF_EN_THETA]) begin
         for (int i = 0; i < KRF_BYTES; i++) begin
            acc = 8'h00;
            for (int j = 0; j < KRF_BYTES; j++) acc = acc ^ gf_times(MIX[j][i], x[8*(7-j) +: 8]);
            mixed[8*i +: 8] = acc;
         end
         x = mixed;
      end
      res.block = x;
      res.last  = lst;
      return res;
   endfunction

   // Random block biased toward all-zero and all-one bytes
   function automatic logic [KRF_BLOCK_W-1:0] random_block();
      logic [KRF_BLOCK_W-1:0] blk;
      blk = {$urandom, $urandom};
      for (int k = 0; k < KRF_BYTES; k++) begin
         case ($urandom_range(7))
            0: blk[8*k +: 8] = 8'h00;
            1: blk[8*k +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return blk;
   endfunction

   // One request; returns at the falling edge after it is taken
   task automatic send_block(input logic [KRF_BLOCK_W-1:0] blk, input logic lst,
                             input logic known, input logic [KRF_BLOCK_W-1:0] golden);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_block_in    <= blk;
      req_last_in_set <= lst;
      req_known       <= known;
      req_golden      <= golden;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every response is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_rounds.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; the local copy follows the write
   task automatic write_register(input logic [KRF_IDX_W-1:0] idx,
                                 input logic [KRF_BLOCK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         KRF_REG_ROUND_KEY:    model_key = data;
         KRF_REG_STAGE_ENABLE: model_enable = data[KRF_EN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver stall, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // Log each taken request and check each taken response
   always @(posedge clock) begin : check_rounds
      round_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_known) begin
               want.block = req_golden;
               want.last  = req_last_in_set;
               expected_rounds.push_back(want);
            end else begin
               expected_rounds.push_back(khazad_round(req_block_in, req_last_in_set));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rounds.size() == 0) begin
               $error("unexpected response: block_out %h, last_out %b",
                      rsp_block_out, rsp_last_out);
               mismatch_count++;
            end else begin
               want = expected_rounds.pop_front();
               if (rsp_block_out !== want.block) begin
                  $error("block_out: expected %h, actual %h", want.block, rsp_block_out);
                  mismatch_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %b, actual %b", want.last, rsp_last_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_khazad_round_function_unit NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_block_in       = '0;
      req_last_in_set    = 1'b0;
      req_known          = 1'b0;
      req_golden         = '0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = KRF_REG_ROUND_KEY;
      csr_wdata          = '0;
      model_key          = '0;
      model_enable       = KRF_EN_RESET;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      sender_idle_pct    = 31;
      receiver_stall_pct = 31;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table; registers rewritten only when a row needs another setting
      foreach (directed_rows[r]) begin
         if (directed_rows[r].key != model_key || directed_rows[r].enable != model_enable) begin
            drain_pipeline();
            if (directed_rows[r].key != model_key)
               write_register(KRF_REG_ROUND_KEY, directed_rows[r].key);
            if (directed_rows[r].enable != model_enable)
               write_register(KRF_REG_STAGE_ENABLE, KRF_BLOCK_W'(directed_rows[r].enable));
         end
         send_block(directed_rows[r].block, directed_rows[r].last,
                    directed_rows[r].known, directed_rows[r].result);
      end

      // Writes to unused indexes are dropped; a wide mask keeps its low bits
      drain_pipeline();
      write_register(REG_INDEX_UNUSED, ALL_ONES);
      write_register(REG_INDEX_TOP, {$urandom, $urandom});
      write_register(KRF_REG_STAGE_ENABLE, 64'hFFFF_FFFF_FFFF_FFFB);
      send_block(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, '0);
      send_block(ALL_ONES, 1'b0, 1'b0, '0);
      send_block(random_block(), 1'b1, 1'b0, '0);

      // Random segments: new key and mask each time, idle pattern rotates
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_pipeline();
         case (seg % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         case (seg % 3)
            0: write_register(KRF_REG_ROUND_KEY, {$urandom, $urandom});
            1: write_register(KRF_REG_ROUND_KEY, ALL_ONES);
            default: write_register(KRF_REG_ROUND_KEY, '0);
         endcase
         write_register(KRF_REG_STAGE_ENABLE,
                        {$urandom, $urandom_range(32'hFFFF_FFFF) & ~32'h7} | SEGMENT_MASKS[seg]);
         repeat (BLOCKS_PER_SEGMENT) send_block(random_block(), 1'($urandom_range(1)), 1'b0, '0);
      end

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("tb_khazad_round_function_unit OK");
      end else begin
         $display("tb_khazad_round_function_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: khazad_round_function_unit.f
hdl/krf_pkg.sv
hdl/krf_theta.sv
hdl/khazad_round_function_unit.sv
test/tb_khazad_round_function_unit.sv
